/* src/tpct_pkg.sv */
// Shared types and constants of the two-phase countdown timer.
package tpct_pkg;

    localparam int unsigned DUR_W     = 32;
    localparam int unsigned CYC_W     = DUR_W + 1;
    localparam int unsigned CAP_W     = 12;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned SECS_W    = 23;
    localparam int unsigned MIN_W     = 17;
    localparam int unsigned SEC_W     = 6;
    localparam int unsigned OUT_W     = 72;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_TAP   = 2'd1;
    localparam logic [OP_W-1:0] OP_ENTER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK = 2'd1;

    localparam logic [DUR_W-1:0] FOCUS_RESET = 32'd1500000;
    localparam logic [DUR_W-1:0] BREAK_RESET = 32'd300000;
    localparam logic [CAP_W-1:0] CAPTION_MS  = 12'd2500;

    // floor(x/1000) = (x * MUL_1000) >> 38 for any 32-bit x
    localparam logic [28:0] MUL_1000 = 29'h10624DD3;
    localparam int unsigned SH_1000  = 38;
    // floor(s/60) = (s * MUL_60) >> 32 for s below 2^23
    localparam logic [26:0] MUL_60   = 27'h4444445;
    localparam int unsigned SH_60    = 32;

    typedef struct packed {
        logic exec;       // apply accepted beat
        logic div_start;  // launch remainder unit
        logic walk;       // one phase-walk step
        logic conv1;      // ms -> seconds multiply
        logic conv2;      // seconds -> minutes multiply
        logic load_out;   // capture result beat
    } t_cmd;

    typedef struct packed {
        logic exec_walk;      // tick crossed a phase boundary
        logic rest_ge_cycle;  // leftover spans a full focus+break cycle
        logic div_done;       // remainder ready
        logic rest_ge_left;   // leftover covers the current phase
    } t_stat;

endpackage

/* src/tpct_rem.sv */
// Bit-serial remainder unit: 32-bit dividend modulo 33-bit divisor.
module tpct_rem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tpct_pkg::DUR_W-1:0] i_dividend,
    input  logic [tpct_pkg::CYC_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [tpct_pkg::DUR_W-1:0] o_rem
);
    import tpct_pkg::*;

    localparam int unsigned CNT_W = $clog2(DUR_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CYC_W-1:0] r_acc, n_acc;
    logic [DUR_W-1:0] r_shift, n_shift;
    logic [CYC_W-1:0] r_div;
    logic [CYC_W:0]   acc_sh;

    assign acc_sh = {r_acc, r_shift[DUR_W-1]};

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_shift = r_shift;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CNT_W'(DUR_W - 1);
            n_acc   = '0;
            n_shift = i_dividend;
        end else if (r_busy) begin
            n_shift = {r_shift[DUR_W-2:0], 1'b0};
            if (acc_sh >= {1'b0, r_div}) begin
                n_acc = CYC_W'(acc_sh - {1'b0, r_div});
            end else begin
                n_acc = CYC_W'(acc_sh);
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_shift <= n_shift;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    // acc < divisor and acc <= dividend, so it fits the dividend width
    assign o_done = r_done;
    assign o_rem  = r_acc[DUR_W-1:0];

endmodule

/* src/tpct_dp.sv */
// Datapath: timer state, config registers, phase walk, display conversion.
module tpct_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tpct_pkg::t_cmd                 i_cmd,
    output tpct_pkg::t_stat                o_stat,
    input  logic                           i_cfg_valid,
    input  logic [tpct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tpct_pkg::DUR_W-1:0]     i_cfg_data,
    input  logic [tpct_pkg::OP_W-1:0]      i_op,
    input  logic [tpct_pkg::DUR_W-1:0]     i_dt,
    output logic [tpct_pkg::OUT_W-1:0]     o_out_data
);
    import tpct_pkg::*;

    logic [DUR_W-1:0] r_focus, r_break;
    logic [CYC_W-1:0] r_cycle;
    logic [DUR_W-1:0] eff_focus, eff_break;

    logic             r_brk, n_brk;
    logic             r_run, n_run;
    logic [DUR_W-1:0] r_left, n_left;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic [DUR_W-1:0] r_rest, n_rest;

    logic [DUR_W-1:0] left0;
    logic             dt_lt_left;
    logic [CAP_W-1:0] cap_dec;

    logic             rem_done;
    logic [DUR_W-1:0] rem_val;

    logic [60:0]       r_prod1;
    logic [SECS_W-1:0] r_secs;
    logic [49:0]       r_prod2;
    logic [MIN_W-1:0]  minutes;
    logic [SECS_W-1:0] min_x60;
    logic [SEC_W-1:0]  seconds;
    logic              cap_act;
    logic [CAP_W-1:0]  cap_elapsed;
    logic [OUT_W-1:0]  r_out;

    // zero-length durations behave as 1 ms
    assign eff_focus = (r_focus == '0) ? DUR_W'(1) : r_focus;
    assign eff_break = (r_break == '0) ? DUR_W'(1) : r_break;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus <= FOCUS_RESET;
            r_break <= BREAK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FOCUS: r_focus <= i_cfg_data;
                CFG_BREAK: r_break <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cycle <= {1'b0, eff_focus} + {1'b0, eff_break};
    end

    assign left0      = (r_left == '0) ? DUR_W'(1) : r_left;
    assign dt_lt_left = i_dt < left0;
    assign cap_dec    = (i_dt < {{(DUR_W-CAP_W){1'b0}}, r_cap}) ? r_cap - i_dt[CAP_W-1:0]
                                                                : '0;

    always_comb begin
        n_brk  = r_brk;
        n_run  = r_run;
        n_left = r_left;
        n_cap  = r_cap;
        n_rest = r_rest;
        if (i_cmd.exec) begin
            case (i_op)
                OP_TICK: begin
                    n_cap = cap_dec;
                    if (r_run) begin
                        if (dt_lt_left) begin
                            n_left = left0 - i_dt;
                        end else begin
                            n_rest = i_dt - left0;
                            n_brk  = ~r_brk;
                            n_left = r_brk ? eff_focus : eff_break;
                            n_cap  = CAPTION_MS;
                        end
                    end
                end
                OP_TAP:   n_run = ~r_run;
                OP_ENTER: begin
                    n_brk  = 1'b0;
                    n_left = eff_focus;
                    n_run  = 1'b0;
                    n_cap  = '0;
                end
                default: ;
            endcase
        end else if (rem_done) begin
            n_rest = rem_val;
        end else if (i_cmd.walk) begin
            if (r_rest >= r_left) begin
                n_rest = r_rest - r_left;
                n_brk  = ~r_brk;
                n_left = r_brk ? eff_focus : eff_break;
                n_cap  = CAPTION_MS;
            end else begin
                n_left = r_left - r_rest;
                n_rest = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk  <= 1'b0;
            r_run  <= 1'b0;
            r_left <= FOCUS_RESET;
            r_cap  <= '0;
            r_rest <= '0;
        end else begin
            r_brk  <= n_brk;
            r_run  <= n_run;
            r_left <= n_left;
            r_cap  <= n_cap;
            r_rest <= n_rest;
        end
    end

    tpct_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rest),
        .i_divisor  (r_cycle),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    assign o_stat.exec_walk     = (i_op == OP_TICK) && r_run && !dt_lt_left;
    assign o_stat.rest_ge_cycle = {1'b0, r_rest} >= r_cycle;
    assign o_stat.div_done      = rem_done;
    assign o_stat.rest_ge_left  = r_rest >= r_left;

    // display: ms -> seconds -> minutes by reciprocal multiplies
    always_ff @(posedge i_clk) begin
        if (i_cmd.conv1) begin
            r_prod1 <= 61'(r_left) * 61'(MUL_1000);
        end
        if (i_cmd.conv2) begin
            r_secs  <= r_prod1[SH_1000 +: SECS_W];
            r_prod2 <= 50'(r_prod1[SH_1000 +: SECS_W]) * 50'(MUL_60);
        end
    end

    assign minutes     = r_prod2[SH_60 +: MIN_W];
    assign min_x60     = SECS_W'({minutes, 6'd0}) - SECS_W'({minutes, 2'd0});
    assign seconds     = SEC_W'(r_secs - min_x60);
    assign cap_act     = r_cap != '0;
    assign cap_elapsed = cap_act ? CAPTION_MS - r_cap : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= {2'b00, cap_elapsed, cap_act, seconds, minutes, r_left, r_brk, r_run};
        end
    end

    assign o_out_data = r_out;

endmodule

/* src/tpct_ctrl.sv */
// Controller: sequences each beat through update, walk, conversion and output.
module tpct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  tpct_pkg::t_stat i_stat,
    output tpct_pkg::t_cmd  o_cmd
);
    import tpct_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_CONV1 = 3'd4;
    localparam logic [2:0] S_CONV2 = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_stat.exec_walk ? S_CHK : S_CONV1;
                end
            end
            S_CHK: begin
                if (i_stat.rest_ge_cycle) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_stat.rest_ge_left) begin
                    n_state = S_CONV1;
                end
            end
            S_CONV1: begin
                o_cmd.conv1 = 1'b1;
                n_state     = S_CONV2;
            end
            S_CONV2: begin
                o_cmd.conv2 = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.load_out | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

/* src/two_phase_countdown_timer.sv */
// Top level of the two-phase (focus / break) countdown timer.
//
//  channel   direction  beat fields
//  s_axis    in         tuser: opcode[1:0]; tdata: dt_ms[31:0]
//  m_axis    out        tdata: status, time left, min/sec, caption
//  cfg       in         i_cfg_index selects register, i_cfg_data is the value
//
// Steps: a beat that crosses no phase boundary goes through accept, two
//   reciprocal-multiply stages and output load. A tick crossing a boundary
//   adds a check and the phase walk, plus a remainder pass if the leftover
//   spans a full focus+break cycle (bit-serial unit, one bit per cycle).
// Reset: synchronous, active low; focus phase, paused, caption off, default
//   durations. No clearing pass.
// Stalls: the result sits in an output register; the next beat is processed
//   meanwhile and waits only at the output load.
module two_phase_countdown_timer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tpct_pkg::DUR_W-1:0]     s_axis_tdata,   // [31:0] dt_ms
    input  logic [tpct_pkg::OP_W-1:0]      s_axis_tuser,   // [1:0] opcode
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] is_running, [1] in_break, [33:2] time_left_ms, [50:34] minutes_shown,
    // [56:51] seconds_shown, [57] caption_active, [69:58] caption_elapsed_ms,
    // [71:70] zero
    output logic [tpct_pkg::OUT_W-1:0]     m_axis_tdata,
    // config write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tpct_pkg::DUR_W-1:0]     i_cfg_data
);
    import tpct_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // the user must make config writes land only while idle; the block does not enforce it and gives no back-pressure
    assign o_cfg_ready = 1'b1;

    tpct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tpct_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_dt        (s_axis_tdata),
        .o_out_data  (m_axis_tdata)
    );

endmodule
